/* rtl/core/labc_pkg.sv */
// Package for the link adaptive bitrate controller: register map, request
// kinds, timing constants, microcode word format and program ROM.
// No dependencies.
package labc_pkg;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned PC_W      = 3;
  localparam int unsigned PROD_W    = 40;
  localparam int unsigned FRAC_BITS = 14;

  localparam logic [31:0] POLL_PERIOD_MS = 32'd1000;
  localparam logic [31:0] ROI_SETTLE_MS  = 32'd2000;
  localparam logic [31:0] URGENT_GAP_MS  = 32'd250;

  localparam logic [2:0] REG_MARGIN     = 3'd0;
  localparam logic [2:0] REG_BACKOFF    = 3'd1;
  localparam logic [2:0] REG_FLOOR      = 3'd2;
  localparam logic [2:0] REG_CEILING    = 3'd3;
  localparam logic [2:0] REG_HYSTERESIS = 3'd4;
  localparam logic [2:0] REG_APPLY_GAP  = 3'd5;
  localparam logic [2:0] REG_BACKLOG    = 3'd6;
  localparam logic [2:0] REG_ROI_CEIL   = 3'd7;

  typedef enum logic [1:0] {
    KIND_NORMAL  = 2'd0,
    KIND_URGENT  = 2'd1,
    KIND_ROI_ON  = 2'd2,
    KIND_ROI_OFF = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_IDLE        = 3'd0,
    OP_MUL_BACKOFF = 3'd1,
    OP_URGENT      = 3'd2,
    OP_MUL_MARGIN  = 3'd3,
    OP_MUL_HYST    = 3'd4,
    OP_NORMAL      = 3'd5,
    OP_DRAIN       = 3'd6,
    OP_NOP         = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    COND_ALWAYS     = 2'd0,
    COND_NO_INPUT   = 2'd1,
    COND_NO_GATE    = 2'd2,
    COND_OUT_BUSY   = 2'd3
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] kbps;
    logic        roi;
  } result_t;

  function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      3'd0:    w = '{op: OP_IDLE,        cond: COND_NO_INPUT, target: 3'd0};
      3'd1:    w = '{op: OP_MUL_BACKOFF, cond: COND_NO_GATE,  target: 3'd3};
      3'd2:    w = '{op: OP_URGENT,      cond: COND_ALWAYS,   target: 3'd3};
      3'd3:    w = '{op: OP_MUL_MARGIN,  cond: COND_NO_GATE,  target: 3'd6};
      3'd4:    w = '{op: OP_MUL_HYST,    cond: COND_ALWAYS,   target: 3'd5};
      3'd5:    w = '{op: OP_NORMAL,      cond: COND_ALWAYS,   target: 3'd6};
      3'd6:    w = '{op: OP_DRAIN,       cond: COND_OUT_BUSY, target: 3'd6};
      default: w = '{op: OP_NOP,         cond: COND_ALWAYS,   target: 3'd0};
    endcase
    return w;
  endfunction

  function automatic logic [23:0] scale_clamp(input logic [PROD_W-1:0] prod,
                                              input logic [23:0] floor_kbps,
                                              input logic [23:0] ceil_kbps);
    logic [PROD_W-FRAC_BITS-1:0] v;
    logic [23:0]                 r;
    v = prod[PROD_W-1:FRAC_BITS];
    if (v < {2'b00, floor_kbps}) begin
      r = floor_kbps;
    end else if (v > {2'b00, ceil_kbps}) begin
      r = ceil_kbps;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/link_adaptive_bitrate_controller.sv */
// Link adaptive bitrate controller, top level: APB register file, microcoded
// sequencer with a shared product register, two-entry result buffer.
// Depends on labc_pkg.
// A tick is accepted only while the sequencer is idle, so a new tick waits until
// every result beat of the last one has drained. The eight-step program steps one
// control word per cycle, except while it waits at the idle or the drain step.
// Reset: rst_ni low clears registers to defaults, state to zero, sequencer idle.
module link_adaptive_bitrate_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [labc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] tick_ms_i,
  input  logic        ring_valid_i,
  input  logic [15:0] backlog_slots_i,
  input  logic        wake_event_i,
  input  logic        link_valid_i,
  input  logic [23:0] link_kbps_i,
  input  logic        urgent_accept_i,
  input  logic        normal_accept_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  request_kind_o,
  output logic [23:0] bitrate_kbps_o,
  output logic        roi_on_attached_o,
  output logic        last_of_tick_o
);

  logic [15:0] margin_q, backoff_q, hyst_q, gap_q, thr_q;
  logic [23:0] floor_q, ceil_q, roi_ceil_q;

  logic [23:0] applied_q, applied_d;
  logic        has_applied_q, has_applied_d;
  logic [31:0] apply_time_q, apply_time_d;
  logic        roi_active_q, roi_active_d;
  logic [31:0] backlog_time_q, backlog_time_d;
  logic [31:0] roi_off_try_q, roi_off_try_d;

  logic [labc_pkg::PC_W-1:0] pc_q, pc_d;
  labc_pkg::ctrl_t           cw;

  logic [31:0] now_q;
  logic        ring_valid_q, wake_q, link_valid_q, uacc_q, nacc_q;
  logic [15:0] backlog_q;
  logic [23:0] link_q;

  logic [labc_pkg::PROD_W-1:0] prod_q, prod_d, hprod_q, hprod_d;
  logic [23:0] target_q, target_d, diff_q, diff_d;

  labc_pkg::result_t res_q [2];
  labc_pkg::result_t push_res;
  logic              push;
  logic [1:0]        cnt_q, cnt_d, rd_q, rd_d;

  logic        in_acc, out_acc, cfg_wr;
  logic        cond_hit;
  logic [31:0] since_apply, since_backlog, since_off;
  logic [23:0] cut_target;
  logic        cut, roi_wanted, go;
  logic [labc_pkg::PROD_W-1:0] diff_sh;

  assign cw          = labc_pkg::ucode_rom(pc_q);
  assign in_stall_o  = (cw.op != labc_pkg::OP_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cw.op == labc_pkg::OP_DRAIN) && (rd_q != cnt_q);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;

  assign request_kind_o    = res_q[rd_q[0]].kind;
  assign bitrate_kbps_o    = res_q[rd_q[0]].kbps;
  assign roi_on_attached_o = res_q[rd_q[0]].roi;
  assign last_of_tick_o    = (rd_q + 2'd1) == cnt_q;

  assign since_apply   = now_q - apply_time_q;
  assign since_backlog = now_q - backlog_time_q;
  assign since_off     = now_q - roi_off_try_q;
  assign cut_target    = labc_pkg::scale_clamp(prod_q, floor_q, ceil_q);
  assign cut           = cut_target < applied_q;
  assign roi_wanted    = applied_q < roi_ceil_q;
  assign diff_sh       = {diff_q, 16'h0000};

  always_comb begin
    case (paddr[labc_pkg::ADDR_W-1:2])
      labc_pkg::REG_MARGIN:     prdata = {16'h0000, margin_q};
      labc_pkg::REG_BACKOFF:    prdata = {16'h0000, backoff_q};
      labc_pkg::REG_FLOOR:      prdata = {8'h00, floor_q};
      labc_pkg::REG_CEILING:    prdata = {8'h00, ceil_q};
      labc_pkg::REG_HYSTERESIS: prdata = {16'h0000, hyst_q};
      labc_pkg::REG_APPLY_GAP:  prdata = {16'h0000, gap_q};
      labc_pkg::REG_BACKLOG:    prdata = {16'h0000, thr_q};
      labc_pkg::REG_ROI_CEIL:   prdata = {8'h00, roi_ceil_q};
      default:                  prdata = 32'h0;
    endcase
  end

  always_comb begin
    case (cw.cond)
      labc_pkg::COND_ALWAYS:   cond_hit = 1'b1;
      labc_pkg::COND_NO_INPUT: cond_hit = !in_acc;
      labc_pkg::COND_NO_GATE: begin
        if (cw.op == labc_pkg::OP_MUL_BACKOFF) begin
          cond_hit = !(ring_valid_q && has_applied_q && since_apply >= labc_pkg::URGENT_GAP_MS);
        end else begin
          cond_hit = !((!has_applied_q || since_apply >= labc_pkg::POLL_PERIOD_MS ||
                        wake_q) && link_valid_q);
        end
      end
      labc_pkg::COND_OUT_BUSY: cond_hit = (rd_q != cnt_q);
      default:                 cond_hit = 1'b1;
    endcase
    pc_d = cond_hit ? cw.target : pc_q + 1'b1;
  end

  always_comb begin
    applied_d      = applied_q;
    has_applied_d  = has_applied_q;
    apply_time_d   = apply_time_q;
    roi_active_d   = roi_active_q;
    backlog_time_d = backlog_time_q;
    roi_off_try_d  = roi_off_try_q;
    prod_d         = prod_q;
    hprod_d        = hprod_q;
    target_d       = target_q;
    diff_d         = diff_q;
    cnt_d          = cnt_q;
    rd_d           = rd_q;
    push           = 1'b0;
    push_res       = '{kind: labc_pkg::KIND_NORMAL, kbps: 24'h0, roi: 1'b0};
    go             = 1'b0;

    case (cw.op)
      labc_pkg::OP_IDLE: begin
        if (in_acc) begin
          cnt_d = 2'd0;
          rd_d  = 2'd0;
        end
      end
      labc_pkg::OP_MUL_BACKOFF: begin
        prod_d = {16'h0000, applied_q} * {24'h000000, backoff_q};
      end
      labc_pkg::OP_URGENT: begin
        if (backlog_q >= thr_q) begin
          backlog_time_d = now_q;
          if (cut || (roi_wanted && !roi_active_q)) begin
            push = 1'b1;
            if (cut) begin
              push_res = '{kind: labc_pkg::KIND_URGENT, kbps: cut_target,
                           roi: roi_wanted && !roi_active_q};
            end else begin
              push_res = '{kind: labc_pkg::KIND_ROI_ON, kbps: 24'h0, roi: 1'b0};
            end
            if (uacc_q) begin
              if (cut) begin
                applied_d    = cut_target;
                apply_time_d = now_q;
              end
              if (roi_wanted) begin
                roi_active_d = 1'b1;
              end
            end
          end
        end else if (roi_active_q && !roi_wanted &&
                     since_backlog >= labc_pkg::ROI_SETTLE_MS &&
                     since_off >= labc_pkg::URGENT_GAP_MS) begin
          roi_off_try_d = now_q;
          push          = 1'b1;
          push_res      = '{kind: labc_pkg::KIND_ROI_OFF, kbps: 24'h0, roi: 1'b0};
          if (uacc_q) begin
            roi_active_d = 1'b0;
          end
        end
      end
      labc_pkg::OP_MUL_MARGIN: begin
        prod_d = {16'h0000, link_q} * {24'h000000, margin_q};
      end
      labc_pkg::OP_MUL_HYST: begin
        target_d = cut_target;
        diff_d   = (cut_target > applied_q) ? cut_target - applied_q
                                            : applied_q - cut_target;
        hprod_d  = {24'h000000, hyst_q} * {16'h0000, applied_q};
      end
      labc_pkg::OP_NORMAL: begin
        go = !has_applied_q ||
             (!(diff_sh < hprod_q) && since_apply >= {16'h0000, gap_q});
        if (go) begin
          push     = 1'b1;
          push_res = '{kind: labc_pkg::KIND_NORMAL, kbps: target_q, roi: 1'b0};
          if (nacc_q) begin
            applied_d     = target_q;
            has_applied_d = 1'b1;
            apply_time_d  = now_q;
          end
        end
      end
      labc_pkg::OP_DRAIN: begin
        if (out_acc) begin
          rd_d = rd_q + 2'd1;
        end
      end
      default: begin
      end
    endcase

    if (push) begin
      cnt_d = cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q       <= 16'd13107;
      backoff_q      <= 16'd11469;
      floor_q        <= 24'd1000;
      ceil_q         <= 24'd20000;
      hyst_q         <= 16'd6554;
      gap_q          <= 16'd500;
      thr_q          <= 16'd2;
      roi_ceil_q     <= 24'd4000;
      applied_q      <= 24'h0;
      has_applied_q  <= 1'b0;
      apply_time_q   <= 32'h0;
      roi_active_q   <= 1'b0;
      backlog_time_q <= 32'h0;
      roi_off_try_q  <= 32'h0;
      pc_q           <= '0;
      cnt_q          <= 2'd0;
      rd_q           <= 2'd0;
    end else begin
      if (cfg_wr) begin
        case (paddr[labc_pkg::ADDR_W-1:2])
          labc_pkg::REG_MARGIN:     margin_q   <= pwdata[15:0];
          labc_pkg::REG_BACKOFF:    backoff_q  <= pwdata[15:0];
          labc_pkg::REG_FLOOR:      floor_q    <= pwdata[23:0];
          labc_pkg::REG_CEILING:    ceil_q     <= pwdata[23:0];
          labc_pkg::REG_HYSTERESIS: hyst_q     <= pwdata[15:0];
          labc_pkg::REG_APPLY_GAP:  gap_q      <= pwdata[15:0];
          labc_pkg::REG_BACKLOG:    thr_q      <= pwdata[15:0];
          labc_pkg::REG_ROI_CEIL:   roi_ceil_q <= pwdata[23:0];
          default: begin
          end
        endcase
      end
      applied_q      <= applied_d;
      has_applied_q  <= has_applied_d;
      apply_time_q   <= apply_time_d;
      roi_active_q   <= roi_active_d;
      backlog_time_q <= backlog_time_d;
      roi_off_try_q  <= roi_off_try_d;
      pc_q           <= pc_d;
      cnt_q          <= cnt_d;
      rd_q           <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q        <= tick_ms_i;
      ring_valid_q <= ring_valid_i;
      backlog_q    <= backlog_slots_i;
      wake_q       <= wake_event_i;
      link_valid_q <= link_valid_i;
      link_q       <= link_kbps_i;
      uacc_q       <= urgent_accept_i;
      nacc_q       <= normal_accept_i;
    end
    prod_q   <= prod_d;
    hprod_q  <= hprod_d;
    target_q <= target_d;
    diff_q   <= diff_d;
    if (push) begin
      res_q[cnt_q[0]] <= push_res;
    end
  end

endmodule

/* dv/labc_checker.sv */
// Checker for the link adaptive bitrate controller: follows register writes,
// predicts the requests of every accepted tick and compares each result beat.
// Depends on labc_pkg.
module labc_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [labc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [31:0]                 tick_ms_i,
  input  logic                        ring_valid_i,
  input  logic [15:0]                 backlog_slots_i,
  input  logic                        wake_event_i,
  input  logic                        link_valid_i,
  input  logic [23:0]                 link_kbps_i,
  input  logic                        urgent_accept_i,
  input  logic                        normal_accept_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [1:0]                  request_kind_i,
  input  logic [23:0]                 bitrate_kbps_i,
  input  logic                        roi_on_attached_i,
  input  logic                        last_of_tick_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          tick_count_o,
  output int                          beat_count_o,
  output int                          urgent_count_o,
  output int                          roi_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    labc_pkg::kind_e kind;
    logic [23:0]     kbps;
    logic            roi;
    logic            last;
  } request_t;

  request_t    pending_requests[$];
  request_t    want;

  logic [15:0] margin_q14, backoff_q14, hyst_q16, gap_ms, threshold;
  logic [23:0] floor_kbps, ceiling_kbps, roi_ceiling_kbps;

  logic [23:0] applied_kbps;
  logic        has_applied;
  logic [31:0] apply_ms;
  logic        roi_active;
  logic [31:0] backlog_ms;
  logic [31:0] roi_off_ms;

  int          fails, ticks, beats, urgents, rois;

  function automatic logic [23:0] scale_clamped(input logic [23:0] base,
                                                input logic [15:0] factor);
    logic [39:0] prod;
    logic [25:0] scaled;
    logic [23:0] clamped;
    prod   = {16'd0, base} * {24'd0, factor};
    scaled = prod[39:14];
    if (scaled < {2'b00, floor_kbps}) begin
      clamped = floor_kbps;
    end else if (scaled > {2'b00, ceiling_kbps}) begin
      clamped = ceiling_kbps;
    end else begin
      clamped = scaled[23:0];
    end
    return clamped;
  endfunction

  function automatic request_t make_request(input labc_pkg::kind_e kind,
                                            input logic [23:0] kbps, input logic roi);
    request_t r;
    r.kind = kind;
    r.kbps = kbps;
    r.roi  = roi;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_tick(input logic [31:0] now, input logic ring,
                              input logic [15:0] backlog, input logic wake,
                              input logic link_ok, input logic [23:0] link,
                              input logic urgent_ok, input logic normal_ok);
    request_t    first_req;
    request_t    second_req;
    int          n;
    logic [23:0] target;
    logic [23:0] diff;
    logic        cut, roi_wanted, poll_ready, go;
    logic [31:0] since_apply;
    logic [47:0] change, band;
    n           = 0;
    first_req   = '0;
    second_req  = '0;
    since_apply = now - apply_ms;
    if (ring && has_applied && since_apply >= labc_pkg::URGENT_GAP_MS) begin
      if (backlog >= threshold) begin
        target     = scale_clamped(applied_kbps, backoff_q14);
        cut        = target < applied_kbps;
        roi_wanted = applied_kbps < roi_ceiling_kbps;
        backlog_ms = now;
        if (cut || (roi_wanted && !roi_active)) begin
          if (cut) begin
            first_req = make_request(labc_pkg::KIND_URGENT, target,
                                     roi_wanted && !roi_active);
          end else begin
            first_req = make_request(labc_pkg::KIND_ROI_ON, 24'd0, 1'b0);
          end
          n = 1;
          if (urgent_ok) begin
            if (cut) begin
              applied_kbps = target;
              apply_ms     = now;
            end
            if (roi_wanted) begin
              roi_active = 1'b1;
            end
          end
        end
      end else if (roi_active && applied_kbps >= roi_ceiling_kbps &&
                   (now - backlog_ms) >= labc_pkg::ROI_SETTLE_MS &&
                   (now - roi_off_ms) >= labc_pkg::URGENT_GAP_MS) begin
        roi_off_ms = now;
        first_req  = make_request(labc_pkg::KIND_ROI_OFF, 24'd0, 1'b0);
        n          = 1;
        if (urgent_ok) begin
          roi_active = 1'b0;
        end
      end
    end

    since_apply = now - apply_ms;
    poll_ready  = !has_applied || since_apply >= labc_pkg::POLL_PERIOD_MS;
    if ((poll_ready || wake) && link_ok) begin
      target = scale_clamped(link, margin_q14);
      go     = 1'b1;
      if (has_applied) begin
        diff   = (target > applied_kbps) ? target - applied_kbps : applied_kbps - target;
        change = {8'd0, diff, 16'd0};
        band   = {32'd0, hyst_q16} * {24'd0, applied_kbps};
        if (change < band || since_apply < {16'd0, gap_ms}) begin
          go = 1'b0;
        end
      end
      if (go) begin
        if (n == 0) begin
          first_req = make_request(labc_pkg::KIND_NORMAL, target, 1'b0);
        end else begin
          second_req = make_request(labc_pkg::KIND_NORMAL, target, 1'b0);
        end
        n++;
        if (normal_ok) begin
          applied_kbps = target;
          has_applied  = 1'b1;
          apply_ms     = now;
        end
      end
    end

    if (n == 1) begin
      first_req.last = 1'b1;
      pending_requests.push_back(first_req);
    end else if (n == 2) begin
      second_req.last = 1'b1;
      pending_requests.push_back(first_req);
      pending_requests.push_back(second_req);
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      fails++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q14       = 16'd13107;
      backoff_q14      = 16'd11469;
      floor_kbps       = 24'd1000;
      ceiling_kbps     = 24'd20000;
      hyst_q16         = 16'd6554;
      gap_ms           = 16'd500;
      threshold        = 16'd2;
      roi_ceiling_kbps = 24'd4000;
      applied_kbps     = '0;
      has_applied      = 1'b0;
      apply_ms         = '0;
      roi_active       = 1'b0;
      backlog_ms       = '0;
      roi_off_ms       = '0;
      pending_requests.delete();
      fails   = 0;
      ticks   = 0;
      beats   = 0;
      urgents = 0;
      rois    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[labc_pkg::ADDR_W-1:2])
          labc_pkg::REG_MARGIN:     margin_q14       = pwdata[15:0];
          labc_pkg::REG_BACKOFF:    backoff_q14      = pwdata[15:0];
          labc_pkg::REG_FLOOR:      floor_kbps       = pwdata[23:0];
          labc_pkg::REG_CEILING:    ceiling_kbps     = pwdata[23:0];
          labc_pkg::REG_HYSTERESIS: hyst_q16         = pwdata[15:0];
          labc_pkg::REG_APPLY_GAP:  gap_ms           = pwdata[15:0];
          labc_pkg::REG_BACKLOG:    threshold        = pwdata[15:0];
          labc_pkg::REG_ROI_CEIL:   roi_ceiling_kbps = pwdata[23:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        beats++;
        if (request_kind_i == labc_pkg::KIND_URGENT) begin
          urgents++;
        end
        if (roi_on_attached_i || request_kind_i == labc_pkg::KIND_ROI_ON ||
            request_kind_i == labc_pkg::KIND_ROI_OFF) begin
          rois++;
        end
        if (pending_requests.size() == 0) begin
          fails++;
          $display("%0t: request beat with nothing expected: kind %0d kbps %0d roi %0b last %0b",
                   $time, request_kind_i, bitrate_kbps_i, roi_on_attached_i, last_of_tick_i);
        end else begin
          want = pending_requests.pop_front();
          check_field("request_kind", 32'(want.kind), 32'(request_kind_i));
          check_field("bitrate_kbps", 32'(want.kbps), 32'(bitrate_kbps_i));
          check_field("roi_on_attached", 32'(want.roi), 32'(roi_on_attached_i));
          check_field("last_of_tick", 32'(want.last), 32'(last_of_tick_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        ticks++;
        predict_tick(tick_ms_i, ring_valid_i, backlog_slots_i, wake_event_i, link_valid_i,
                     link_kbps_i, urgent_accept_i, normal_accept_i);
      end
    end
    fail_count_o   <= fails;
    pending_o      <= pending_requests.size();
    tick_count_o   <= ticks;
    beat_count_o   <= beats;
    urgent_count_o <= urgents;
    roi_count_o    <= rois;
  end

endmodule

/* dv/tb_top.sv */
// Testbench top for the link adaptive bitrate controller: clock, reset,
// register setup, tick stimulus and result stalls; verdict from labc_checker.
// Depends on labc_pkg, labc_checker and the controller RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_TICKS   = 100;

  logic                        clk_i           = 1'b0;
  logic                        rst_ni          = 1'b0;
  logic                        psel            = 1'b0;
  logic                        penable         = 1'b0;
  logic                        pwrite          = 1'b0;
  logic [labc_pkg::ADDR_W-1:0] paddr           = '0;
  logic [31:0]                 pwdata          = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        in_valid_i      = 1'b0;
  logic                        in_stall_o;
  logic [31:0]                 tick_ms_i       = '0;
  logic                        ring_valid_i    = 1'b0;
  logic [15:0]                 backlog_slots_i = '0;
  logic                        wake_event_i    = 1'b0;
  logic                        link_valid_i    = 1'b0;
  logic [23:0]                 link_kbps_i     = '0;
  logic                        urgent_accept_i = 1'b0;
  logic                        normal_accept_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i     = 1'b0;
  logic [1:0]                  request_kind_o;
  logic [23:0]                 bitrate_kbps_o;
  logic                        roi_on_attached_o;
  logic                        last_of_tick_o;

  int                fail_count, pending, tick_count, beat_count, urgent_count, roi_count;
  int unsigned       cycles       = 0;
  logic [31:0]       now_ms       = 32'hFFFF_FFFF;
  logic [31:0]       cfg [labc_pkg::NUM_REGS];
  logic              hold_pending = 1'b0;
  logic              no_idle      = 1'b0;
  int                burst_left   = 0;
  int                link_base    = 5000;
  int                settings     = 0;

  always #4 clk_i = ~clk_i;

  link_adaptive_bitrate_controller i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .tick_ms_i         (tick_ms_i),
    .ring_valid_i      (ring_valid_i),
    .backlog_slots_i   (backlog_slots_i),
    .wake_event_i      (wake_event_i),
    .link_valid_i      (link_valid_i),
    .link_kbps_i       (link_kbps_i),
    .urgent_accept_i   (urgent_accept_i),
    .normal_accept_i   (normal_accept_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .request_kind_o    (request_kind_o),
    .bitrate_kbps_o    (bitrate_kbps_o),
    .roi_on_attached_o (roi_on_attached_o),
    .last_of_tick_o    (last_of_tick_o)
  );

  labc_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .tick_ms_i         (tick_ms_i),
    .ring_valid_i      (ring_valid_i),
    .backlog_slots_i   (backlog_slots_i),
    .wake_event_i      (wake_event_i),
    .link_valid_i      (link_valid_i),
    .link_kbps_i       (link_kbps_i),
    .urgent_accept_i   (urgent_accept_i),
    .normal_accept_i   (normal_accept_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .request_kind_i    (request_kind_o),
    .bitrate_kbps_i    (bitrate_kbps_o),
    .roi_on_attached_i (roi_on_attached_o),
    .last_of_tick_i    (last_of_tick_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .tick_count_o      (tick_count),
    .beat_count_o      (beat_count),
    .urgent_count_o    (urgent_count),
    .roi_count_o       (roi_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] margin, input logic [31:0] backoff,
                            input logic [31:0] floor_v, input logic [31:0] ceil_v,
                            input logic [31:0] hyst, input logic [31:0] gap,
                            input logic [31:0] thresh, input logic [31:0] roi_ceil);
    cfg[labc_pkg::REG_MARGIN]     = margin;
    cfg[labc_pkg::REG_BACKOFF]    = backoff;
    cfg[labc_pkg::REG_FLOOR]      = floor_v;
    cfg[labc_pkg::REG_CEILING]    = ceil_v;
    cfg[labc_pkg::REG_HYSTERESIS] = hyst;
    cfg[labc_pkg::REG_APPLY_GAP]  = gap;
    cfg[labc_pkg::REG_BACKLOG]    = thresh;
    cfg[labc_pkg::REG_ROI_CEIL]   = roi_ceil;
    for (int i = 0; i < labc_pkg::NUM_REGS; i++) begin
      write_reg(i[2:0], cfg[i]);
    end
    settings++;
  endtask

  task automatic drive_tick(input logic [31:0] dt, input logic ring,
                            input logic [15:0] backlog, input logic wake,
                            input logic link_ok, input logic [23:0] link,
                            input logic urgent_ok, input logic normal_ok);
    int gap;
    gap    = no_idle ? 0 : $urandom_range(0, 3);
    now_ms = now_ms + dt;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    tick_ms_i       <= now_ms;
    ring_valid_i    <= ring;
    backlog_slots_i <= backlog;
    wake_event_i    <= wake;
    link_valid_i    <= link_ok;
    link_kbps_i     <= link;
    urgent_accept_i <= urgent_ok;
    normal_accept_i <= normal_ok;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drain every outstanding request, then let a silent tick finish
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_tick();
    int          roll, thresh, jitter;
    logic [31:0] dt;
    logic [15:0] backlog;
    logic [23:0] link;
    thresh = int'(cfg[labc_pkg::REG_BACKLOG] & 32'hFFFF);
    roll   = $urandom_range(0, 99);
    if (roll < 5) begin
      dt = $urandom;
    end else if (roll < 15) begin
      dt = $urandom_range(0, 49);
    end else if (roll < 25) begin
      dt = $urandom_range(151, 3000);
    end else begin
      dt = $urandom_range(50, 150);
    end
    if (burst_left == 0 && $urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(1, 6);
    end
    if ($urandom_range(0, 19) == 0) begin
      backlog = 16'($urandom_range(0, 65535));
    end else if (burst_left > 0) begin
      burst_left--;
      backlog = (thresh > 65532) ? 16'hFFFF : 16'(thresh + int'($urandom_range(0, 3)));
    end else if (thresh == 0) begin
      backlog = 16'd0;
    end else begin
      backlog = 16'($urandom_range(0, thresh - 1));
    end
    if ($urandom_range(0, 19) == 0) begin
      link_base = $urandom_range(500, 30000);
    end
    if ($urandom_range(0, 9) == 0) begin
      link = 24'($urandom_range(0, 24'hFFFFFF));
    end else begin
      jitter = int'($urandom_range(0, link_base / 4));
      link   = 24'(link_base - link_base / 8 + jitter);
    end
    drive_tick(dt, $urandom_range(0, 9) != 0, backlog, $urandom_range(0, 4) == 0,
               $urandom_range(0, 9) != 0, link, $urandom_range(0, 6) != 0,
               $urandom_range(0, 6) != 0);
  endtask

  task automatic run_phase(input int count);
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= 40 && i < 60);
      if (i == 70) begin
        hold_pending = 1'b1;
      end
      random_tick();
    end
    no_idle = 1'b0;
    settle();
  endtask

  initial begin
    int unsigned stall_len;
    @(posedge clk_i);
    forever begin
      if (hold_pending) begin
        stall_len    = HOLD_CYCLES;
        hold_pending = 1'b0;
      end else begin
        stall_len = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (stall_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the default settings through every request kind
    drive_tick(0,    1'b0, 16'd0,      1'b0, 1'b0, 24'd0,        1'b0, 1'b0);
    drive_tick(1,    1'b1, 16'd5,      1'b0, 1'b1, 24'd0,        1'b1, 1'b0);
    drive_tick(100,  1'b1, 16'd0,      1'b0, 1'b1, 24'd10000,    1'b1, 1'b1);
    drive_tick(100,  1'b1, 16'd9,      1'b1, 1'b1, 24'hFFFFFF,   1'b1, 1'b1);
    drive_tick(100,  1'b1, 16'd2,      1'b0, 1'b1, 24'd10000,    1'b0, 1'b1);
    drive_tick(100,  1'b1, 16'hFFFF,   1'b0, 1'b0, 24'd0,        1'b1, 1'b1);
    drive_tick(300,  1'b1, 16'd3,      1'b0, 1'b1, 24'd0,        1'b1, 1'b1);
    drive_tick(300,  1'b1, 16'd3,      1'b0, 1'b1, 24'd0,        1'b1, 1'b1);
    drive_tick(300,  1'b1, 16'd3,      1'b0, 1'b1, 24'd0,        1'b1, 1'b1);
    drive_tick(300,  1'b1, 16'd3,      1'b0, 1'b1, 24'd0,        1'b1, 1'b1);
    drive_tick(300,  1'b1, 16'd3,      1'b0, 1'b1, 24'd0,        1'b1, 1'b1);
    drive_tick(300,  1'b1, 16'd3,      1'b0, 1'b1, 24'd0,        1'b1, 1'b1);
    drive_tick(600,  1'b1, 16'd0,      1'b1, 1'b1, 24'd10000,    1'b1, 1'b1);
    drive_tick(100,  1'b1, 16'd0,      1'b1, 1'b1, 24'd10200,    1'b1, 1'b1);
    drive_tick(1500, 1'b1, 16'd0,      1'b0, 1'b0, 24'd0,        1'b0, 1'b0);
    drive_tick(100,  1'b1, 16'd0,      1'b0, 1'b0, 24'd0,        1'b1, 1'b0);
    drive_tick(200,  1'b1, 16'd0,      1'b0, 1'b0, 24'd0,        1'b1, 1'b0);
    drive_tick(100,  1'b1, 16'd0,      1'b1, 1'b1, 24'd1250,     1'b1, 1'b1);
    drive_tick(300,  1'b1, 16'd2,      1'b0, 1'b1, 24'd0,        1'b1, 1'b1);
    drive_tick(300,  1'b1, 16'd2,      1'b1, 1'b1, 24'd20000,    1'b1, 1'b1);
    drive_tick(600,  1'b1, 16'd2,      1'b1, 1'b1, 24'd5000,     1'b0, 1'b1);
    drive_tick(1000, 1'b0, 16'hFFFF,   1'b0, 1'b1, 24'hFFFFFF,   1'b1, 1'b1);
    drive_tick(100,  1'b1, 16'd0,      1'b0, 1'b0, 24'd0,        1'b1, 1'b1);
    settle();

    set_config(13107, 11469, 1000, 20000, 6554, 500, 2, 4000);
    run_phase(PHASE_TICKS);
    set_config(65535, 65535, 0, 24'hFFFFFF, 0, 0, 0, 24'hFFFFFF);
    run_phase(PHASE_TICKS);
    set_config(0, 0, 0, 0, 0, 0, 0, 0);
    run_phase(PHASE_TICKS);
    set_config(16384, 8192, 5000, 3000, 65535, 65535, 65535, 6000);
    run_phase(PHASE_TICKS);
    set_config(16384, 4096, 100, 100000, 1000, 100, 100, 50000);
    run_phase(PHASE_TICKS);
    set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
               $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
               $urandom_range(0, 65535), $urandom_range(0, 65535),
               $urandom_range(0, 65535), $urandom_range(0, 24'hFFFFFF));
    run_phase(PHASE_TICKS);
    set_config($urandom_range(8192, 24576), $urandom_range(4096, 16383),
               $urandom_range(0, 3000), $urandom_range(10000, 40000),
               $urandom_range(0, 16384), $urandom_range(0, 1000),
               $urandom_range(0, 8), $urandom_range(1000, 20000));
    run_phase(PHASE_TICKS);
    set_config(13107, 11469, 1000, 20000, 6554, 500, 2, 4000);
    run_phase(PHASE_TICKS);

    $display("Ran %0d ticks under %0d register settings, %0d request beats compared.",
             tick_count, settings, beat_count);
    $display("Urgent cuts seen: %0d, beats touching ROI: %0d.", urgent_count, roi_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
